// ===== src/wsfr_pkg.sv =====
// Package for the WebSocket frame receiver: parser phases, result kinds,
// the result record and reset constants. No dependencies.
`timescale 1ns / 1ps

package wsfr_pkg;

  // Parser phase, 3-bit encoding; unused codes behave as HDR0
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  // Result kind as carried on out_tuser
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_TOO_LONG = 2'd2
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic       last;
    logic       fin;
    logic [3:0] frame_opcode;
  } res_t;

  localparam int unsigned LEN_W = 63;
  localparam int unsigned MAX_W = 32;

  localparam logic [MAX_W-1:0] MAX_PAYLOAD_RST = 32'd65536;

  // Second header byte length codes
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // Header byte counts for extended length and mask key
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_BYTES = 3'd0;  // eight bytes, wraps through zero
  localparam logic [2:0] KEY_BYTES   = 3'd4;

endpackage

// ===== src/wsfr_parser.sv =====
// Frame parser: per-byte state registers and the combinational step logic
// that turns one received byte into at most one result. Uses wsfr_pkg.
`timescale 1ns / 1ps

module wsfr_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,       // byte transfer this cycle
  input  logic [7:0]                        rx_byte,
  input  logic                              cfg_wr,
  input  logic [wsfr_pkg::MAX_W-1:0]        cfg_wdata,
  output logic                              res_valid,
  output wsfr_pkg::res_t                    res
);

  wsfr_pkg::phase_t                   phase_r, phase_nxt;
  logic                               fin_r, fin_nxt;
  logic [3:0]                         op_r, op_nxt;
  logic                               masked_r, masked_nxt;
  logic [2:0]                         cnt_r, cnt_nxt;
  logic [wsfr_pkg::LEN_W-1:0]         len_r, len_nxt;
  logic [31:0]                        key_r, key_nxt;
  logic [wsfr_pkg::LEN_W-1:0]         rem_r, rem_nxt;
  logic                               skip_r, skip_nxt;
  logic [wsfr_pkg::MAX_W-1:0]         max_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= wsfr_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_wr) begin
      max_r <= cfg_wdata;
    end
  end

  // Step logic
  always_comb begin
    logic                       hdr_len_done;  // length known
    logic                       hdr_start;     // header complete, decide frame
    logic [wsfr_pkg::LEN_W-1:0] len_sel;
    logic [2:0]                 cnt_dec;
    logic                       too_long;
    logic [7:0]                 key_byte;
    logic [wsfr_pkg::LEN_W-1:0] rem_dec;
    logic                       is_last;

    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    op_nxt     = op_r;
    masked_nxt = masked_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    rem_nxt    = rem_r;
    skip_nxt   = skip_r;

    res_valid        = 1'b0;
    res.kind         = wsfr_pkg::KIND_PAYLOAD;
    res.payload_byte = 8'd0;
    res.last         = 1'b1;
    res.fin          = fin_r;
    res.frame_opcode = op_r;

    hdr_len_done = 1'b0;
    hdr_start    = 1'b0;
    len_sel      = len_r;
    cnt_dec      = cnt_r - 3'd1;
    key_byte     = 8'd0;
    rem_dec      = rem_r - {{(wsfr_pkg::LEN_W-1){1'b0}}, 1'b1};
    is_last      = (rem_dec == '0);

    case (phase_r)
      wsfr_pkg::PH_HDR1: begin
        masked_nxt = rx_byte[7];
        if (rx_byte[6:0] == wsfr_pkg::LEN7_EXT16) begin
          len_nxt   = '0;
          cnt_nxt   = wsfr_pkg::EXT16_BYTES;
          phase_nxt = wsfr_pkg::PH_EXT;
        end else if (rx_byte[6:0] == wsfr_pkg::LEN7_EXT64) begin
          len_nxt   = '0;
          cnt_nxt   = wsfr_pkg::EXT64_BYTES;
          phase_nxt = wsfr_pkg::PH_EXT;
        end else begin
          len_sel      = {{(wsfr_pkg::LEN_W-7){1'b0}}, rx_byte[6:0]};
          len_nxt      = len_sel;
          hdr_len_done = 1'b1;
        end
      end
      wsfr_pkg::PH_EXT: begin
        // big-endian shift-in, top bit of a 64-bit length drops off
        len_sel = {len_r[wsfr_pkg::LEN_W-9:0], rx_byte};
        len_nxt = len_sel;
        cnt_nxt = cnt_dec;
        if (cnt_dec == 3'd0) begin
          hdr_len_done = 1'b1;
        end
      end
      wsfr_pkg::PH_MASK: begin
        key_nxt = {key_r[23:0], rx_byte};
        cnt_nxt = cnt_dec;
        if (cnt_dec == 3'd0) begin
          hdr_start = 1'b1;
        end
      end
      wsfr_pkg::PH_DATA: begin
        // first key byte received sits in the top byte
        case (cnt_r[1:0])
          2'd0:    key_byte = key_r[31:24];
          2'd1:    key_byte = key_r[23:16];
          2'd2:    key_byte = key_r[15:8];
          default: key_byte = key_r[7:0];
        endcase
        if (!masked_r) begin
          key_byte = 8'd0;
        end
        cnt_nxt = cnt_r + 3'd1;
        rem_nxt = rem_dec;
        if (is_last) begin
          phase_nxt = wsfr_pkg::PH_HDR0;
          cnt_nxt   = 3'd0;
        end
        if (skip_r) begin
          if (is_last) begin
            skip_nxt = 1'b0;
          end
        end else begin
          res_valid        = 1'b1;
          res.kind         = wsfr_pkg::KIND_PAYLOAD;
          res.payload_byte = rx_byte ^ key_byte;
          res.last         = is_last;
        end
      end
      default: begin
        fin_nxt   = rx_byte[7];
        op_nxt    = rx_byte[3:0];
        skip_nxt  = 1'b0;
        phase_nxt = wsfr_pkg::PH_HDR1;
      end
    endcase

    // Length known: mask key next, or complete the header now
    if (hdr_len_done) begin
      if (rx_byte[7] && phase_r == wsfr_pkg::PH_HDR1 ||
          masked_r && phase_r != wsfr_pkg::PH_HDR1) begin
        key_nxt   = '0;
        cnt_nxt   = wsfr_pkg::KEY_BYTES;
        phase_nxt = wsfr_pkg::PH_MASK;
      end else begin
        hdr_start = 1'b1;
      end
    end

    // Header complete: too long, empty or payload
    too_long = (len_sel[wsfr_pkg::LEN_W-1:wsfr_pkg::MAX_W] != '0) ||
               (len_sel[wsfr_pkg::MAX_W-1:0] > max_r);
    if (hdr_start) begin
      cnt_nxt = 3'd0;
      if (too_long) begin
        res_valid = 1'b1;
        res.kind  = wsfr_pkg::KIND_TOO_LONG;
        rem_nxt   = len_sel;
        skip_nxt  = 1'b1;
        phase_nxt = wsfr_pkg::PH_DATA;
      end else if (len_sel == '0) begin
        res_valid = 1'b1;
        res.kind  = wsfr_pkg::KIND_EMPTY;
        phase_nxt = wsfr_pkg::PH_HDR0;
      end else begin
        rem_nxt   = len_sel;
        skip_nxt  = 1'b0;
        phase_nxt = wsfr_pkg::PH_DATA;
      end
    end

    if (!step) begin
      res_valid = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsfr_pkg::PH_HDR0;
      fin_r    <= 1'b0;
      op_r     <= 4'd0;
      masked_r <= 1'b0;
      cnt_r    <= 3'd0;
      len_r    <= '0;
      key_r    <= '0;
      rem_r    <= '0;
      skip_r   <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      fin_r    <= fin_nxt;
      op_r     <= op_nxt;
      masked_r <= masked_nxt;
      cnt_r    <= cnt_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      rem_r    <= rem_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule

// ===== src/wsfr_out_buf.sv =====
// Two-entry result buffer: the output register plus a skid register so the
// input keeps flowing while a result waits. Uses wsfr_pkg.
`timescale 1ns / 1ps

module wsfr_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wsfr_pkg::res_t  push_res,
  output logic            can_accept,
  output logic            out_valid,
  input  logic            out_ready,
  output wsfr_pkg::res_t  out_res
);

  logic           main_vld_r, main_vld_nxt;
  logic           spare_vld_r, spare_vld_nxt;
  wsfr_pkg::res_t main_r, main_nxt;
  wsfr_pkg::res_t spare_r, spare_nxt;
  logic           pop;

  assign can_accept = !spare_vld_r;
  assign out_valid  = main_vld_r;
  assign out_res    = main_r;
  assign pop        = main_vld_r && out_ready;

  // Occupancy and data movement; push never coincides with a full spare
  always_comb begin
    main_vld_nxt  = main_vld_r;
    spare_vld_nxt = spare_vld_r;
    main_nxt      = main_r;
    spare_nxt     = spare_r;
    if (pop) begin
      main_vld_nxt  = spare_vld_r;
      main_nxt      = spare_r;
      spare_vld_nxt = 1'b0;
    end
    if (push) begin
      if (!main_vld_r || (pop && !spare_vld_r)) begin
        main_vld_nxt = 1'b1;
        main_nxt     = push_res;
      end else begin
        spare_vld_nxt = 1'b1;
        spare_nxt     = push_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r  <= 1'b0;
      spare_vld_r <= 1'b0;
    end else begin
      main_vld_r  <= main_vld_nxt;
      spare_vld_r <= spare_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r  <= main_nxt;
    spare_r <= spare_nxt;
  end

endmodule

// ===== src/websocket_frame_receiver.sv =====
// WebSocket frame receiver top level: byte stream in, parsed result stream
// out. Depends on wsfr_pkg, wsfr_parser and wsfr_out_buf.
//
// Usage:
//   in_*   : one received byte per transfer (in_tdata[7:0]).
//   out_*  : one result per transfer. out_tuser is the kind (payload byte,
//            empty frame, frame too long); out_tlast marks the last result
//            of a frame; out_tdata carries the unmasked byte, FIN, opcode.
//   cfg_*  : write of max_payload, always ready; write only while idle.
// Header bytes give no result; an empty or over-long frame reports once on
// its last header byte, and an over-long payload is dropped.
// Throughput: one byte per cycle while in_tready is high, set by the parser
// step logic (63-bit length decrement and compare against max_payload).
// A result is registered in the output buffer when its byte is taken.
// A two-entry output buffer lets input continue while one result waits;
// in_tready drops only when two results are held.
// Reset: synchronous active-low rst_n returns the parser to the first header
// byte, empties the output buffer and sets max_payload to 65536.
`timescale 1ns / 1ps

module websocket_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] payload_byte, [8] fin, [12:9] frame_opcode
  output logic [1:0]  out_tuser,   // [1:0] kind
  output logic        out_tlast,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data     // max_payload
);

  logic           step;
  logic           res_valid;
  wsfr_pkg::res_t res;
  wsfr_pkg::res_t out_res;
  logic           can_accept;

  assign in_tready = can_accept;
  assign step      = in_tvalid && can_accept;
  assign cfg_ready = 1'b1;

  wsfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_tdata),
    .cfg_wr    (cfg_valid),
    .cfg_wdata (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfr_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_res   (res),
    .can_accept (can_accept),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (out_res)
  );

  // Output packing
  assign out_tdata = {3'b000, out_res.frame_opcode, out_res.fin, out_res.payload_byte};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

  // Checks
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("illegal result kind");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != wsfr_pkg::KIND_PAYLOAD |-> out_tlast)
    else $error("empty/error result not marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != wsfr_pkg::KIND_PAYLOAD |-> out_tdata[7:0] == 8'd0)
    else $error("empty/error result with nonzero byte");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

endmodule

// ===== bench/websocket_frame_receiver_test.sv =====
// Self-checking bench for websocket_frame_receiver: builds WebSocket frames byte
// by byte, predicts the parsed results and compares every output transfer.
// Depends on wsfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module websocket_frame_receiver_test;

  // Length field forms of the second header byte
  localparam int FORM_LEN7  = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;

  localparam int NUM_PHASES  = 8;
  localparam int PHASE_BYTES = 220;

  // Parser model plus the queue of results it still expects to see
  class frame_checker;
    wsfr_pkg::phase_t ph;
    logic             fin_f;
    logic [3:0]       op;
    logic             masked;
    logic [2:0]       cnt;
    logic [62:0]      len;
    logic [62:0]      rem;
    logic [31:0]      key;
    logic             skip;
    logic [31:0]      max_len;
    wsfr_pkg::res_t   due_results[$];
    int               mismatches;

    function new();
      ph         = wsfr_pkg::PH_HDR0;
      fin_f      = 1'b0;
      op         = '0;
      masked     = 1'b0;
      cnt        = '0;
      len        = '0;
      rem        = '0;
      key        = '0;
      skip       = 1'b0;
      max_len    = wsfr_pkg::MAX_PAYLOAD_RST;
      mismatches = 0;
    endfunction

    function void push(wsfr_pkg::kind_t k, logic [7:0] d, logic l);
      wsfr_pkg::res_t r;
      r.kind         = k;
      r.payload_byte = d;
      r.last         = l;
      r.fin          = fin_f;
      r.frame_opcode = op;
      due_results.push_back(r);
    endfunction

    // Header complete: error, empty frame or start of payload
    function void header_done();
      cnt = '0;
      if (len > 63'(max_len)) begin
        push(wsfr_pkg::KIND_TOO_LONG, 8'h00, 1'b1);
        rem  = len;
        skip = 1'b1;
        ph   = wsfr_pkg::PH_DATA;
      end else if (len == '0) begin
        push(wsfr_pkg::KIND_EMPTY, 8'h00, 1'b1);
        ph = wsfr_pkg::PH_HDR0;
      end else begin
        rem  = len;
        skip = 1'b0;
        ph   = wsfr_pkg::PH_DATA;
      end
    endfunction

    function void length_known();
      if (masked) begin
        key = '0;
        cnt = wsfr_pkg::KEY_BYTES;
        ph  = wsfr_pkg::PH_MASK;
      end else begin
        header_done();
      end
    endfunction

    // One accepted input byte
    function void take_byte(logic [7:0] b);
      logic [1:0] pos;
      logic [7:0] k;
      case (ph)
        wsfr_pkg::PH_HDR1: begin
          masked = b[7];
          len    = '0;
          if (b[6:0] == wsfr_pkg::LEN7_EXT16) begin
            cnt = wsfr_pkg::EXT16_BYTES;
            ph  = wsfr_pkg::PH_EXT;
          end else if (b[6:0] == wsfr_pkg::LEN7_EXT64) begin
            cnt = wsfr_pkg::EXT64_BYTES;
            ph  = wsfr_pkg::PH_EXT;
          end else begin
            len = 63'(b[6:0]);
            length_known();
          end
        end
        wsfr_pkg::PH_EXT: begin
          // big-endian, top bit of a 64-bit length falls off
          len = {len[54:0], b};
          cnt = cnt - 3'd1;
          if (cnt == '0) length_known();
        end
        wsfr_pkg::PH_MASK: begin
          key = {key[23:0], b};
          cnt = cnt - 3'd1;
          if (cnt == '0) header_done();
        end
        wsfr_pkg::PH_DATA: begin
          pos = cnt[1:0];
          k   = masked ? 8'(key >> (24 - 8 * pos)) : 8'h00;
          cnt = cnt + 3'd1;
          rem = rem - 63'd1;
          if (rem == '0) begin
            ph  = wsfr_pkg::PH_HDR0;
            cnt = '0;
          end
          if (skip) begin
            if (rem == '0) skip = 1'b0;
          end else begin
            push(wsfr_pkg::KIND_PAYLOAD, b ^ k, rem == '0);
          end
        end
        default: begin
          fin_f = b[7];
          op    = b[3:0];
          skip  = 1'b0;
          ph    = wsfr_pkg::PH_HDR1;
        end
      endcase
    endfunction

    // One accepted output transfer against the oldest expectation
    function void check_result(logic [15:0] data, logic [1:0] user, logic last);
      wsfr_pkg::res_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind %0d byte %02h last %0b fin %0b op %0h",
                   $realtime, user, data[7:0], last, data[8], data[12:9]);
        return;
      end
      want = due_results.pop_front();
      if (user != want.kind || data[7:0] != want.payload_byte || last != want.last ||
          data[8] != want.fin || data[12:9] != want.frame_opcode) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: expected kind %0d byte %02h last %0b fin %0b op %0h, ",
                    "got %0d %02h %0b %0b %0h"},
                   $realtime, want.kind, want.payload_byte, want.last, want.fin,
                   want.frame_opcode, user, data[7:0], last, data[8], data[12:9]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  frame_checker board;
  bit           in_burst = 1'b0;
  bit           out_burst = 1'b0;
  int           accepted = 0;

  websocket_frame_receiver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin : clock_gen
    forever #10 clk = ~clk;
  end

  // One byte transfer; valid stays high when the next byte follows at once
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.take_byte(b);
    accepted++;
  endtask

  // Header, optional key and the first 'sent' payload bytes of one frame
  task automatic send_frame(input logic [7:0] hdr0, input bit masked, input int form,
                            input int unsigned plen, input int unsigned sent,
                            input bit top);
    logic [63:0] ext;
    logic [31:0] mkey;
    send_byte(hdr0);
    ext = {top, 63'(plen)};
    case (form)
      FORM_EXT16: begin
        send_byte({masked, wsfr_pkg::LEN7_EXT16});
        send_byte(ext[15:8]);
        send_byte(ext[7:0]);
      end
      FORM_EXT64: begin
        send_byte({masked, wsfr_pkg::LEN7_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(ext[8*i +: 8]);
      end
      default: send_byte({masked, 7'(plen)});
    endcase
    mkey = $urandom;
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(mkey[8*i +: 8]);
    for (int unsigned i = 0; i < sent; i++) send_byte(8'($urandom));
  endtask

  task automatic send_random_frame();
    int unsigned plen;
    int unsigned sent;
    int          form;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)      plen = $urandom_range(0, 12);
    else if (pick < 92) plen = $urandom_range(13, 40);
    else                plen = $urandom_range(41, 300);
    if (plen > 125 || $urandom_range(0, 9) >= 6)
      form = $urandom_range(FORM_EXT16, FORM_EXT64);
    else
      form = FORM_LEN7;
    sent = plen;
    // now and then cut the payload short; following bytes finish it
    if (plen > 1 && $urandom_range(0, 9) == 0) sent = $urandom_range(0, plen - 1);
    in_burst  = ($urandom_range(0, 4) == 0);
    out_burst = ($urandom_range(0, 4) == 0);
    send_frame(8'($urandom), 1'($urandom), form, plen, sent, 1'($urandom));
    // random fill up to the next frame start, short 7-bit lengths only
    while (board.ph != wsfr_pkg::PH_HDR0)
      send_byte(board.ph == wsfr_pkg::PH_HDR1 ?
                {1'($urandom), 7'($urandom_range(0, 125))} : 8'($urandom));
  endtask

  task automatic write_max(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.max_len = v;
  endtask

  // Stop input, wait for every expected result, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side with random backpressure
  initial begin : result_sink
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      board.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  initial begin : stimulus
    logic [31:0] lim;
    int          target;
    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset limit
    send_frame(8'h8F, 1'b0, FORM_LEN7, 0, 0, 1'b0);   // empty, FIN, top opcode
    send_frame(8'h01, 1'b1, FORM_LEN7, 0, 0, 1'b0);   // masked empty, reports on key
    send_frame(8'hF2, 1'b1, FORM_LEN7, 4, 4, 1'b0);   // reserved bits set, key order
    send_frame(8'h09, 1'b0, FORM_EXT64, 2, 2, 1'b1);  // ping, 64-bit length, MSB set
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       lim = 32'hFFFF_FFFF;
        1:       lim = 32'h0;
        2:       lim = $urandom_range(0, 15);
        3:       lim = wsfr_pkg::MAX_PAYLOAD_RST;
        4:       lim = $urandom;
        5:       lim = $urandom_range(0, 40);
        6:       lim = 32'd1;
        default: lim = $urandom_range(0, 300);
      endcase
      write_max(lim);
      target = accepted + PHASE_BYTES;
      while (accepted < target) send_random_frame();
      drain();
    end

    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.due_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
